FILE: src/tcp_receiver_reorder_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// TCP receive reorder tracker assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef TCP_RECEIVER_REORDER_TRACKER_UNIT_ASSERT_SVH
`define TCP_RECEIVER_REORDER_TRACKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/trt_pkg.sv
// ----------------------------------------------------------------------------
// TCP receive reorder tracker package
// Shared widths, reset values, codes, item types and state types.
// ----------------------------------------------------------------------------
package trt_pkg;

    localparam int OFFSET_W       = 31;
    localparam int SENDER_W       = 16;
    localparam int SIZE_W         = 16;
    localparam int WINREG_W       = 7;
    localparam int ACK_W          = 32;
    localparam int DRAIN_W        = 7;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 64;
    localparam int CFG_DATA_W     = 16;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int DIV_STEPS      = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [SIZE_W-1:0]   SEG_SIZE_RESET = 16'd1460;
    localparam logic [WINREG_W-1:0] WINDOW_RESET   = 7'd32;

    typedef enum logic {
        REG_SEGMENT_SIZE    = 1'b0,
        REG_WINDOW_SEGMENTS = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OUTCOME_IN_ORDER = 2'd0,
        OUTCOME_BUFFERED = 2'd1,
        OUTCOME_OLD      = 2'd2,
        OUTCOME_OVERFLOW = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [SENDER_W-1:0] sender_id;
        logic [OFFSET_W-1:0] segment_offset;
    } item_t;

    typedef struct packed {
        logic [DRAIN_W-1:0]  segments_drained;
        logic                new_transfer;
        outcome_t            outcome;
        logic [SENDER_W-1:0] ack_destination;
        logic [ACK_W-1:0]    ack_offset;
    } result_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_CLASS,
        B_DIV_START,
        B_DIV,
        B_DRAIN,
        B_OUT
    } back_state_t;

endpackage

FILE: src/tcp_receiver_reorder_tracker_unit.sv
// ----------------------------------------------------------------------------
// TCP receive reorder tracker
// Tracks the expected byte offset of a TCP transfer, buffers out-of-order
// segments in a window bitmap and returns one acknowledgement per segment.
// ----------------------------------------------------------------------------
// Every accepted segment produces exactly one acknowledgement transfer. The
// front end spends most of each segment in a serial divider that finds the
// window slot of the offset, takes a new segment only once the last is in
// the queue, and overlaps with the back end working on the previous one.
// The back end passes a buffered, old or overflowing segment through its
// load, classify and output states; an in-order segment also runs its own
// 32-step serial divider for the slot of the new expected offset, drains
// buffered slots and reruns the divider when that offset saturates. The
// acknowledgement sits in an output register, so the next segment is
// taken while it waits. Configuration writes act even mid-segment.
// ----------------------------------------------------------------------------
module tcp_receiver_reorder_tracker_unit #(
    parameter int WINDOW_MAX = trt_pkg::WINDOW_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // segment_offset [30:0], sender_id [46:31], zero pad [47]
    input  logic [trt_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ack_offset [31:0], ack_destination [47:32], outcome [49:48],
    // new_transfer [50], segments_drained [57:51], zero pad [63:58]
    output logic [trt_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_index,
    input  logic [trt_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int Q_W    = $bits(trt_pkg::item_t) + SLOT_W;

    logic [trt_pkg::SIZE_W-1:0]   seg_size_reg;
    logic [trt_pkg::WINREG_W-1:0] window_reg;
    logic [trt_pkg::SIZE_W-1:0]   size_eff;
    logic [WIN_W-1:0]             win_eff;

    trt_pkg::item_t     in_item;
    trt_pkg::item_t     front_item;
    logic [SLOT_W-1:0]  front_slot;
    logic               q_push, q_full, q_pop, q_not_empty;
    logic [Q_W-1:0]     q_head;
    trt_pkg::result_t   result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_size_reg <= trt_pkg::SEG_SIZE_RESET;
            window_reg   <= trt_pkg::WINDOW_RESET;
        end else if (cfg_wr_en) begin
            unique case (trt_pkg::cfg_reg_t'(cfg_wr_index))
                trt_pkg::REG_SEGMENT_SIZE:    seg_size_reg <= cfg_wr_data;
                trt_pkg::REG_WINDOW_SEGMENTS: window_reg <= cfg_wr_data[trt_pkg::WINREG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        size_eff = (seg_size_reg == '0) ? trt_pkg::SIZE_W'(1) : seg_size_reg;
        priority if (window_reg == '0) begin
            win_eff = WIN_W'(1);
        end else if (int'(window_reg) > WINDOW_MAX) begin
            win_eff = WIN_W'(WINDOW_MAX);
        end else begin
            win_eff = WIN_W'(window_reg);
        end
    end

    assign in_item.segment_offset = s_tdata[trt_pkg::OFFSET_W-1:0];
    assign in_item.sender_id      = s_tdata[trt_pkg::OFFSET_W +: trt_pkg::SENDER_W];

    trt_front #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .size_eff (size_eff),
        .win_eff  (win_eff),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_item   (front_item),
        .q_slot   (front_slot)
    );

    trt_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({front_slot, front_item}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    trt_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_not_empty),
        .q_item    (trt_pkg::item_t'(q_head[$bits(trt_pkg::item_t)-1:0])),
        .q_slot    (q_head[Q_W-1 -: SLOT_W]),
        .q_pop     (q_pop),
        .size_eff  (size_eff),
        .win_eff   (win_eff),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (result)
    );

    assign m_tdata = {6'b0,
                      result.segments_drained,
                      result.new_transfer,
                      result.outcome,
                      result.ack_destination,
                      result.ack_offset};

endmodule

FILE: src/trt_divmod.sv
// ----------------------------------------------------------------------------
// TCP receive reorder tracker slot divider
// Serial restoring division, one quotient bit per cycle, that keeps the
// quotient reduced modulo the window as the bits arrive.
// ----------------------------------------------------------------------------
module trt_divmod #(
    parameter int WINDOW_MAX = trt_pkg::WINDOW_MAX_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          start,
    input  logic [31:0]                                   dividend,
    input  logic [trt_pkg::SIZE_W-1:0]                    divisor,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]               modulus,
    output logic                                          done,
    output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] slot
);

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(trt_pkg::DIV_STEPS);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [31:0]                 sh_reg, sh_next;
    logic [trt_pkg::SIZE_W-1:0]  rem_reg, rem_next;
    logic [SLOT_W-1:0]           qmod_reg, qmod_next;
    logic [trt_pkg::SIZE_W:0]    trial;
    logic                        qbit;
    logic [SLOT_W:0]             mtrial;
    logic [SLOT_W:0]             mod_ext;
    logic                        mge;

    always_comb begin
        trial   = {rem_reg, sh_reg[31]};
        qbit    = (trial >= {1'b0, divisor});
        mtrial  = {qmod_reg, qbit};
        mod_ext = (SLOT_W + 1)'(modulus);
        mge     = (mtrial >= mod_ext);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        qmod_next = qmod_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = dividend;
            rem_next  = '0;
            qmod_next = '0;
        end else if (busy_reg) begin
            sh_next   = {sh_reg[30:0], 1'b0};
            rem_next  = trt_pkg::SIZE_W'(qbit ? (trial - {1'b0, divisor}) : trial);
            qmod_next = SLOT_W'(mge ? (mtrial - mod_ext) : mtrial);
            cnt_next  = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(trt_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        qmod_reg <= qmod_next;
    end

    assign done = done_reg;
    assign slot = qmod_reg;

endmodule

FILE: src/trt_queue.sv
// ----------------------------------------------------------------------------
// TCP receive reorder tracker item queue
// Small register queue between the slot-finding front and the tracking back.
// ----------------------------------------------------------------------------
module trt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    localparam int DEPTH = trt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    always_comb begin
        do_push     = push && !full;
        do_pop      = pop && not_empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];

endmodule

FILE: src/trt_front.sv
// ----------------------------------------------------------------------------
// TCP receive reorder tracker front end
// Accepts segments and works out the window slot of each offset before
// handing the segment to the queue.
// ----------------------------------------------------------------------------
module trt_front #(
    parameter int WINDOW_MAX = trt_pkg::WINDOW_MAX_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  trt_pkg::item_t                                in_item,
    input  logic [trt_pkg::SIZE_W-1:0]                    size_eff,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]               win_eff,
    output logic                                          q_push,
    input  logic                                          q_full,
    output trt_pkg::item_t                                q_item,
    output logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] q_slot
);

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    trt_pkg::front_state_t state_reg, state_next;
    trt_pkg::item_t        item_reg;
    logic                  accept;
    logic                  div_done;
    logic [SLOT_W-1:0]     div_slot;

    assign accept = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            trt_pkg::F_IDLE: begin
                if (in_valid) begin
                    state_next = trt_pkg::F_DIV;
                end
            end
            trt_pkg::F_DIV: begin
                if (div_done) begin
                    state_next = trt_pkg::F_PUSH;
                end
            end
            trt_pkg::F_PUSH: begin
                if (!q_full) begin
                    state_next = trt_pkg::F_IDLE;
                end
            end
            default: state_next = trt_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        in_ready = (state_reg == trt_pkg::F_IDLE);
        q_push   = (state_reg == trt_pkg::F_PUSH) && !q_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= trt_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (accept) begin
            item_reg <= in_item;
        end
    end

    trt_divmod #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_divmod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend ({1'b0, in_item.segment_offset}),
        .divisor  (size_eff),
        .modulus  (win_eff),
        .done     (div_done),
        .slot     (div_slot)
    );

    assign q_item = item_reg;
    assign q_slot = div_slot;

endmodule

FILE: src/trt_back.sv
// ----------------------------------------------------------------------------
// TCP receive reorder tracker back end
// Holds the expected offset and the arrival bitmap, classifies each queued
// segment, drains buffered slots and registers the acknowledgement.
// ----------------------------------------------------------------------------
`include "tcp_receiver_reorder_tracker_unit_assert.svh"

module trt_back #(
    parameter int WINDOW_MAX = trt_pkg::WINDOW_MAX_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          q_valid,
    input  trt_pkg::item_t                                q_item,
    input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] q_slot,
    output logic                                          q_pop,
    input  logic [trt_pkg::SIZE_W-1:0]                    size_eff,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]               win_eff,
    output logic                                          res_valid,
    input  logic                                          res_ready,
    output trt_pkg::result_t                              res_data
);

    localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int PROD_W = WIN_W + trt_pkg::SIZE_W;
    localparam int LIM_W  = 34 + WIN_W;

    trt_pkg::back_state_t state_reg, state_next;

    trt_pkg::item_t              item_reg, item_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [31:0]                 exp_reg, exp_next;
    logic [PROD_W-1:0]           prod_reg, prod_next;
    logic [SLOT_W-1:0]           exp_slot_reg, exp_slot_next;
    logic [WIN_W-1:0]            drained_reg, drained_next;
    trt_pkg::outcome_t           outcome_reg, outcome_next;
    logic                        restart_reg, restart_next;
    logic [WINDOW_MAX-1:0]       bitmap_reg, bitmap_next;
    logic                        res_valid_reg, res_valid_next;
    trt_pkg::result_t            res_data_reg, res_data_next;

    logic [32:0]                 sum;
    logic [31:0]                 advanced;
    logic                        saturated;
    logic [LIM_W-1:0]            limit;
    logic [LIM_W-1:0]            off_ext;
    logic [LIM_W-1:0]            exp_ext;
    logic [SLOT_W:0]             slot_inc;
    logic                        out_free;
    logic                        drain_stop;
    logic                        div_start;
    logic                        div_done;
    logic [SLOT_W-1:0]           div_slot;

    always_comb begin
        sum        = {1'b0, exp_reg} + {17'b0, size_eff};
        saturated  = sum[32];
        advanced   = saturated ? 32'hFFFF_FFFF : sum[31:0];
        exp_ext    = LIM_W'(exp_reg);
        off_ext    = LIM_W'(item_reg.segment_offset);
        limit      = exp_ext + LIM_W'(prod_reg);
        slot_inc   = (SLOT_W + 1)'(exp_slot_reg) + 1'b1;
        out_free   = !res_valid_reg || res_ready;
        drain_stop = (drained_reg == win_eff) || !bitmap_reg[exp_slot_reg];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            trt_pkg::B_IDLE: begin
                if (q_valid) begin
                    state_next = trt_pkg::B_LOAD;
                end
            end
            trt_pkg::B_LOAD: state_next = trt_pkg::B_CLASS;
            trt_pkg::B_CLASS: begin
                if (off_ext == exp_ext) begin
                    state_next = trt_pkg::B_DIV_START;
                end else begin
                    state_next = trt_pkg::B_OUT;
                end
            end
            trt_pkg::B_DIV_START: state_next = trt_pkg::B_DIV;
            trt_pkg::B_DIV: begin
                if (div_done) begin
                    state_next = trt_pkg::B_DRAIN;
                end
            end
            trt_pkg::B_DRAIN: begin
                if (drain_stop) begin
                    state_next = trt_pkg::B_OUT;
                end else if (saturated) begin
                    state_next = trt_pkg::B_DIV_START;
                end
            end
            trt_pkg::B_OUT: begin
                if (out_free) begin
                    state_next = trt_pkg::B_IDLE;
                end
            end
            default: state_next = trt_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        q_pop          = 1'b0;
        div_start      = 1'b0;
        item_next      = item_reg;
        slot_next      = slot_reg;
        exp_next       = exp_reg;
        prod_next      = prod_reg;
        exp_slot_next  = exp_slot_reg;
        drained_next   = drained_reg;
        outcome_next   = outcome_reg;
        restart_next   = restart_reg;
        bitmap_next    = bitmap_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;

        unique case (state_reg)
            trt_pkg::B_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    item_next = q_item;
                    slot_next = q_slot;
                end
            end
            trt_pkg::B_LOAD: begin
                drained_next = '0;
                prod_next    = PROD_W'(win_eff - 1'b1) * PROD_W'(size_eff);
                restart_next = (item_reg.segment_offset == '0);
                if (item_reg.segment_offset == '0) begin
                    exp_next    = '0;
                    bitmap_next = '0;
                end
            end
            trt_pkg::B_CLASS: begin
                if (off_ext == exp_ext) begin
                    outcome_next = trt_pkg::OUTCOME_IN_ORDER;
                    exp_next     = advanced;
                end else if (off_ext > exp_ext) begin
                    if (off_ext > limit) begin
                        outcome_next = trt_pkg::OUTCOME_OVERFLOW;
                    end else begin
                        outcome_next          = trt_pkg::OUTCOME_BUFFERED;
                        bitmap_next[slot_reg] = 1'b1;
                    end
                end else begin
                    outcome_next = trt_pkg::OUTCOME_OLD;
                end
            end
            trt_pkg::B_DIV_START: begin
                div_start = 1'b1;
            end
            trt_pkg::B_DIV: begin
                if (div_done) begin
                    exp_slot_next = div_slot;
                end
            end
            trt_pkg::B_DRAIN: begin
                if (!drain_stop) begin
                    bitmap_next[exp_slot_reg] = 1'b0;
                    exp_next                  = advanced;
                    drained_next              = WIN_W'(drained_reg + 1'b1);
                    exp_slot_next = (slot_inc == (SLOT_W + 1)'(win_eff)) ? '0
                                                                         : SLOT_W'(slot_inc);
                end
            end
            trt_pkg::B_OUT: begin
                if (out_free) begin
                    res_valid_next                 = 1'b1;
                    res_data_next.ack_offset       = exp_reg - {16'b0, size_eff};
                    res_data_next.ack_destination  = item_reg.sender_id;
                    res_data_next.outcome          = outcome_reg;
                    res_data_next.new_transfer     = restart_reg;
                    res_data_next.segments_drained = trt_pkg::DRAIN_W'(drained_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= trt_pkg::B_IDLE;
            exp_reg       <= '0;
            bitmap_reg    <= '0;
            res_valid_reg <= 1'b0;
            drained_reg   <= '0;
            exp_slot_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            bitmap_reg    <= bitmap_next;
            res_valid_reg <= res_valid_next;
            drained_reg   <= drained_next;
            exp_slot_reg  <= exp_slot_next;
        end
        item_reg     <= item_next;
        slot_reg     <= slot_next;
        prod_reg     <= prod_next;
        outcome_reg  <= outcome_next;
        restart_reg  <= restart_next;
        res_data_reg <= res_data_next;
    end

    trt_divmod #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_divmod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (exp_reg),
        .divisor  (size_eff),
        .modulus  (win_eff),
        .done     (div_done),
        .slot     (div_slot)
    );

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `TRT_ASSERT_IMPLY(a_drain_bound, aclk, aresetn,
        (state_reg == trt_pkg::B_DRAIN), (drained_reg <= win_eff),
        "drain count exceeds the receive window")
    `TRT_ASSERT_IMPLY(a_slot_in_window, aclk, aresetn,
        (state_reg == trt_pkg::B_DRAIN), ((SLOT_W + 1)'(exp_slot_reg) < (SLOT_W + 1)'(win_eff)),
        "expected slot lies outside the receive window")
    `TRT_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        ((state_reg == trt_pkg::B_OUT) && out_free), res_valid_reg,
        "result was not registered when the output stage was free")
    `TRT_ASSERT_IMPLY(a_drain_only_in_order, aclk, aresetn,
        ((state_reg == trt_pkg::B_OUT) && (outcome_reg != trt_pkg::OUTCOME_IN_ORDER)),
        (drained_reg == '0),
        "segments drained on an arrival that was not in order")

endmodule

FILE: sim/trt_ack_checker.sv
// ----------------------------------------------------------------------------
// TCP receive reorder tracker acknowledgement checker
// Watches the segment, acknowledgement and register write ports of the
// tracker, keeps its own copy of the expected offset, the window bitmap and
// the registers, and compares every acknowledgement transfer field by field
// with the oldest predicted acknowledgement.
// ----------------------------------------------------------------------------
module trt_ack_checker
    import trt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    mismatch_count,
    output int                    acks_outstanding
);

    localparam int WIN_SLOTS = WINDOW_MAX_DEF;

    logic [SIZE_W-1:0]   seg_size;
    logic [WINREG_W-1:0] win_reg;
    logic [31:0]         next_offset;
    bit [WIN_SLOTS-1:0]  held_slots;
    result_t             ack_q[$];
    result_t             want_ack;
    result_t             got_ack;

    function automatic logic [31:0] step_offset(input logic [31:0] cur,
                                                input longint unsigned size);
        longint unsigned sum;
        sum = cur + size;
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
    endfunction

    function automatic result_t track_segment(input item_t seg);
        longint unsigned size;
        longint unsigned win;
        longint unsigned off;
        longint unsigned lim;
        int unsigned     slot;
        int unsigned     drained;
        result_t         r;
        size = (seg_size == '0) ? 1 : seg_size;
        if (win_reg == '0) begin
            win = 1;
        end else if (win_reg > WIN_SLOTS) begin
            win = WIN_SLOTS;
        end else begin
            win = win_reg;
        end
        off = seg.segment_offset;
        drained = 0;
        r.new_transfer = 1'b0;
        if (off == 0) begin
            r.new_transfer = 1'b1;
            next_offset = '0;
            held_slots = '0;
        end
        if (off == next_offset) begin
            r.outcome = OUTCOME_IN_ORDER;
            next_offset = step_offset(next_offset, size);
            while (drained < win) begin
                slot = int'((next_offset / size) % win);
                if (!held_slots[slot]) begin
                    break;
                end
                held_slots[slot] = 1'b0;
                next_offset = step_offset(next_offset, size);
                drained++;
            end
        end else if (off > next_offset) begin
            lim = next_offset + (win - 1) * size;
            if (off > lim) begin
                r.outcome = OUTCOME_OVERFLOW;
            end else begin
                held_slots[int'((off / size) % win)] = 1'b1;
                r.outcome = OUTCOME_BUFFERED;
            end
        end else begin
            r.outcome = OUTCOME_OLD;
        end
        r.ack_offset = next_offset - 32'(size);
        r.ack_destination = seg.sender_id;
        r.segments_drained = DRAIN_W'(drained);
        return r;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seg_size = SEG_SIZE_RESET;
            win_reg = WINDOW_RESET;
            next_offset = '0;
            held_slots = '0;
            ack_q.delete();
            mismatch_count = 0;
            acks_outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_reg_t'(cfg_wr_index) == REG_SEGMENT_SIZE) begin
                    seg_size = cfg_wr_data[SIZE_W-1:0];
                end else begin
                    win_reg = cfg_wr_data[WINREG_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got_ack = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (ack_q.size() == 0) begin
                    $display("%0t: acknowledgement expected none, actual %0h", $time,
                             m_tdata);
                    mismatch_count++;
                end else begin
                    want_ack = ack_q.pop_front();
                    report_field("ack_offset", want_ack.ack_offset, got_ack.ack_offset);
                    report_field("ack_destination", want_ack.ack_destination,
                                 got_ack.ack_destination);
                    report_field("outcome", want_ack.outcome, got_ack.outcome);
                    report_field("new_transfer", want_ack.new_transfer,
                                 got_ack.new_transfer);
                    report_field("segments_drained", want_ack.segments_drained,
                                 got_ack.segments_drained);
                end
            end
            if (s_tvalid && s_tready) begin
                ack_q.push_back(track_segment(item_t'(s_tdata[$bits(item_t)-1:0])));
            end
            acks_outstanding <= ack_q.size();
        end
    end

endmodule

FILE: sim/tb_tcp_receiver_reorder_tracker_unit.sv
// ----------------------------------------------------------------------------
// TCP receive reorder tracker testbench
// Drives segments through the tracker under random source gaps and sink
// stalls: a directed run over restarts, in-order arrival with drains up to a
// full window, buffering, old segments, overflow and degenerate register
// values, then randomly reordered transfers over several register settings.
// The acknowledgement checker predicts and compares every transfer.
// ----------------------------------------------------------------------------
module tb_tcp_receiver_reorder_tracker_unit;
    import trt_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 700;
    localparam int DIRECTED_ROOM = 25;
    localparam int PHASES        = 6;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_wr_index = REG_SEGMENT_SIZE;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;

    int          mismatch_count;
    int          acks_outstanding;
    int          idle_cycles = 0;
    int unsigned sent_count = 0;
    int unsigned cur_size = 1460;
    int unsigned cur_win = 32;
    bit          send_calm = 1'b0;
    bit          take_calm = 1'b0;

    always #5 aclk = ~aclk;

    tcp_receiver_reorder_tracker_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    trt_ack_checker ack_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .mismatch_count   (mismatch_count),
        .acks_outstanding (acks_outstanding)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_tcp_receiver_reorder_tracker_unit NOT OK");
            $finish;
        end
    end

    initial begin : ack_sink
        int pause;
        forever begin
            pause = take_calm ? 0 : $urandom_range(0, 16);
            if (pause != 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_segment(input logic [OFFSET_W-1:0] off,
                                input logic [SENDER_W-1:0] sid);
        item_t seg;
        int    gap;
        seg.segment_offset = off;
        seg.sender_id = sid;
        gap = send_calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(seg);
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic configure(input logic [SIZE_W-1:0] size,
                             input logic [WINREG_W-1:0] win);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (acks_outstanding != 0);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= REG_SEGMENT_SIZE;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_index <= REG_WINDOW_SEGMENTS;
        cfg_wr_data <= {9'($urandom_range(0, 511)), win};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_size = (size == '0) ? 1 : size;
        cur_win = (win == '0) ? 1 : ((win > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win);
    endtask

    task automatic run_transfer(input int unsigned nseg);
        int unsigned     order[$];
        int unsigned     k;
        int unsigned     j;
        int unsigned     span;
        int unsigned     tmp;
        longint unsigned off;
        for (k = 1; k <= nseg; k++) begin
            order.push_back(k);
        end
        for (k = 0; k < nseg; k++) begin
            span = (cur_win < nseg - k) ? cur_win : nseg - k;
            j = k + $urandom_range(0, span - 1);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        send_calm = ($urandom_range(0, 3) == 0);
        take_calm = ($urandom_range(0, 3) == 0);
        send_segment('0, SENDER_W'($urandom_range(0, 65535)));
        for (k = 0; k < nseg; k++) begin
            off = longint'(order[k]) * cur_size;
            case ($urandom_range(0, 19))
                0: off = $urandom & 32'h7FFF_FFFF;
                1: off = longint'(order[$urandom_range(0, k)]) * cur_size;
                2: begin
                    if (cur_size > 1) begin
                        off = off + $urandom_range(1, cur_size - 1);
                    end
                end
                default: ;
            endcase
            if ($urandom_range(0, 29) != 0) begin
                send_segment(OFFSET_W'(off), SENDER_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial begin : stimulus
        int p;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_segment(31'd0, 16'h0000);
        send_segment(31'd4380, 16'hFFFF);
        send_segment(31'd2920, 16'h5A5A);
        send_segment(31'd1460, 16'hA5A5);
        send_segment(31'd100, 16'h0001);
        send_segment(31'h7FFF_FFFF, 16'h8000);
        send_segment(31'd0, 16'h7FFF);

        configure(16'd0, 7'd0);
        send_segment(31'd0, 16'h1234);
        send_segment(31'd1, 16'h1234);
        send_segment(31'd2, 16'h1234);
        send_segment(31'd5, 16'h1234);
        send_segment(31'd2, 16'h1234);

        configure(16'hFFFF, 7'd127);
        send_segment(31'd0, 16'h0F0F);
        send_segment(31'd4194240, 16'h0F0F);
        send_segment(31'd4194241, 16'h0F0F);
        send_segment(31'd65535, 16'h0F0F);

        configure(16'd7, 7'd4);
        send_segment(31'd0, 16'h00FF);
        send_segment(31'd8, 16'h00FF);
        send_segment(31'd14, 16'h00FF);
        send_segment(31'd21, 16'h00FF);
        send_segment(31'd28, 16'h00FF);
        send_segment(31'd7, 16'h00FF);
        send_segment(31'd49, 16'h00FF);

        configure(16'd7, 7'd8);
        send_segment(31'd42, 16'hFF00);

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(16'd1460, 7'd32);
                1: configure(16'd0, 7'd0);
                2: configure(16'hFFFF, 7'd127);
                3: configure(SIZE_W'($urandom_range(2, 40)), WINREG_W'($urandom_range(2, 8)));
                4: configure(16'd1, 7'd64);
                default: configure(SIZE_W'($urandom_range(1, 65535)),
                                   WINREG_W'($urandom_range(1, 64)));
            endcase
            while (sent_count < DIRECTED_ROOM + (p + 1) * RANDOM_ITEMS / PHASES) begin
                run_transfer($urandom_range(1, 3 * cur_win));
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (acks_outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && acks_outstanding == 0) begin
            $display("tb_tcp_receiver_reorder_tracker_unit OK");
        end else begin
            $display("tb_tcp_receiver_reorder_tracker_unit NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/trt_pkg.sv
src/trt_divmod.sv
src/trt_queue.sv
src/trt_front.sv
src/trt_back.sv
src/tcp_receiver_reorder_tracker_unit.sv
sim/trt_ack_checker.sv
sim/tb_tcp_receiver_reorder_tracker_unit.sv
